@@ rtl/core/geohash_interleaved_encoder_assert.svh @@
// Assertion macros for the geohash interleaved encoder checker.
// Depends on nothing; included by the checker file.
`ifndef GEOHASH_INTERLEAVED_ENCODER_ASSERT_SVH
`define GEOHASH_INTERLEAVED_ENCODER_ASSERT_SVH

// Antecedent in this cycle implies consequent in this cycle.
`define GHE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Antecedent in this cycle implies consequent in the next cycle.
`define GHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

@@ rtl/core/ghe_pkg.sv @@
// Shared types and constants of the geohash interleaved encoder.
// Depends on nothing; used by every RTL module of the block.
package ghe_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PREC  = 3'd1;
  localparam logic [2:0] ST_BAD_RANGE = 3'd2;
  localparam logic [2:0] ST_GLOBAL    = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;

  localparam logic signed [31:0] GLOBAL_LAT_LIMIT = 32'sd850511287;
  localparam logic signed [31:0] GLOBAL_LON_LIMIT = 32'sd1800000000;

  localparam logic signed [30:0] LAT_MIN_RST = -31'sd850511287;
  localparam logic signed [30:0] LAT_MAX_RST = 31'sd850511287;
  localparam logic signed [31:0] LON_MIN_RST = -32'sd1800000000;
  localparam logic signed [31:0] LON_MAX_RST = 32'sd1800000000;

  localparam logic [1:0] REG_LAT_MIN = 2'd0;
  localparam logic [1:0] REG_LAT_MAX = 2'd1;
  localparam logic [1:0] REG_LON_MIN = 2'd2;
  localparam logic [1:0] REG_LON_MAX = 2'd3;

  typedef struct packed {
    logic signed [31:0] lon_in;
    logic signed [31:0] lat_in;
    logic [7:0]         precision;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_bits;
    logic [7:0]  hash_precision;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic signed [30:0] lat_min;
    logic signed [30:0] lat_max;
    logic signed [31:0] lon_min;
    logic signed [31:0] lon_max;
  } cfg_t;

  // One coordinate in the divider: remainder, divisor, quotient so far.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] q;
    logic        sat;
  } lane_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] precision;
    lane_t      lat;
    lane_t      lon;
  } div_item_t;

endpackage

@@ rtl/core/ghe_front.sv @@
// Input stage: precision, range and bound checks, offsets and spans for the divider.
// Depends on ghe_pkg.
module ghe_front #(
  parameter int MAX_PRECISION = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  ghe_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghe_pkg::div_item_t  out_data
);

  ghe_pkg::div_item_t item_next;
  logic signed [31:0] lat_min_x;
  logic signed [31:0] lat_max_x;
  logic signed [32:0] lat_num;
  logic signed [32:0] lat_den;
  logic signed [32:0] lon_num;
  logic signed [32:0] lon_den;
  logic [2:0]         status;

  assign lat_min_x = 32'(cfg.lat_min);
  assign lat_max_x = 32'(cfg.lat_max);
  assign lat_num = 33'(in_data.lat_in) - 33'(lat_min_x);
  assign lat_den = 33'(lat_max_x) - 33'(lat_min_x);
  assign lon_num = 33'(in_data.lon_in) - 33'(cfg.lon_min);
  assign lon_den = 33'(cfg.lon_max) - 33'(cfg.lon_min);

  always_comb begin
    if (in_data.precision == 8'd0 || in_data.precision > 8'(MAX_PRECISION)) begin
      status = ghe_pkg::ST_BAD_PREC;
    end else if (lat_max_x <= lat_min_x || cfg.lon_max <= cfg.lon_min) begin
      status = ghe_pkg::ST_BAD_RANGE;
    end else if (in_data.lat_in > ghe_pkg::GLOBAL_LAT_LIMIT ||
                 in_data.lat_in < -ghe_pkg::GLOBAL_LAT_LIMIT ||
                 in_data.lon_in > ghe_pkg::GLOBAL_LON_LIMIT ||
                 in_data.lon_in < -ghe_pkg::GLOBAL_LON_LIMIT) begin
      status = ghe_pkg::ST_GLOBAL;
    end else if (in_data.lat_in < lat_min_x || in_data.lat_in > lat_max_x ||
                 in_data.lon_in < cfg.lon_min || in_data.lon_in > cfg.lon_max) begin
      status = ghe_pkg::ST_OUTSIDE;
    end else begin
      status = ghe_pkg::ST_OK;
    end
  end

  always_comb begin
    item_next.status    = status;
    item_next.precision = in_data.precision;
    item_next.lat.rem   = lat_num[31:0];
    item_next.lat.den   = lat_den[31:0];
    item_next.lat.q     = '0;
    item_next.lat.sat   = (lat_num == lat_den);
    item_next.lon.rem   = lon_num[31:0];
    item_next.lon.den   = lon_den[31:0];
    item_next.lon.q     = '0;
    item_next.lon.sat   = (lon_num == lon_den);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= item_next;
    end
  end

endmodule

@@ rtl/core/ghe_div_stage.sv @@
// One restoring-division stage: one quotient bit for both coordinates.
// Depends on ghe_pkg.
module ghe_div_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghe_pkg::div_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghe_pkg::div_item_t  out_data
);

  function automatic ghe_pkg::lane_t step(input ghe_pkg::lane_t l);
    ghe_pkg::lane_t o;
    logic [32:0]    r2;
    logic           ge;
    o  = l;
    r2 = {l.rem, 1'b0};
    ge = (r2 >= {1'b0, l.den});
    o.rem = ge ? 32'(r2 - {1'b0, l.den}) : r2[31:0];
    o.q   = {l.q[30:0], ge};
    return o;
  endfunction

  ghe_pkg::div_item_t item_next;

  always_comb begin
    item_next     = in_data;
    item_next.lat = step(in_data.lat);
    item_next.lon = step(in_data.lon);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= item_next;
    end
  end

endmodule

@@ rtl/core/ghe_interleave.sv @@
// Output stage: trim quotients to the precision, saturate, interleave, zero the hash on error.
// Depends on ghe_pkg.
module ghe_interleave #(
  parameter int MAX_PRECISION = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghe_pkg::div_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghe_pkg::out_item_t  out_data
);

  logic [5:0]          sh;
  logic [32:0]         full;
  logic [31:0]         lat_idx;
  logic [31:0]         lon_idx;
  logic [63:0]         hash;
  ghe_pkg::out_item_t  item_next;

  assign sh   = 6'(MAX_PRECISION) - in_data.precision[5:0];
  assign full = (33'd1 << in_data.precision[5:0]) - 33'd1;
  assign lat_idx = in_data.lat.sat ? full[31:0] : (in_data.lat.q >> sh);
  assign lon_idx = in_data.lon.sat ? full[31:0] : (in_data.lon.q >> sh);

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      hash[2*i]   = lat_idx[i];
      hash[2*i+1] = lon_idx[i];
    end
    item_next.hash_bits      = (in_data.status == ghe_pkg::ST_OK) ? hash : 64'd0;
    item_next.hash_precision = in_data.precision;
    item_next.status         = in_data.status;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= item_next;
    end
  end

endmodule

@@ rtl/core/geohash_interleaved_encoder.sv @@
// Geohash interleaved encoder, top level.
// Depends on ghe_pkg, ghe_front, ghe_div_stage and ghe_interleave.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one transaction per
//   point: longitude, latitude (degrees times 10^7) and precision step.
//   Output channel (out_valid/out_ready/out_data) returns one transaction
//   per input: the interleaved hash, the echoed precision and a status.
//   The APB port writes the four range registers; write them only while
//   no transaction is in flight.
// Pipeline: one check stage, one restoring-division stage per quotient
//   bit and one interleave/output stage, each registered.
// Throughput: one transaction per cycle while out_ready is high; every
//   stage holds its own valid bit, so any stage takes a new transaction
//   when it is empty or when the next stage takes its contents.
// Reset: rst clears all stage valid bits and loads the default ranges
//   (Web-Mercator latitude limits, full longitude).
// Stall: while out_ready is low the output stage holds; bubbles ahead of
//   it still collapse, so the input keeps accepting until the pipe is full.
module geohash_interleaved_encoder #(
  parameter int MAX_PRECISION = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghe_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghe_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  ghe_pkg::cfg_t cfg;

  // Stage chain: index 0 is the check stage output, index k the k-th
  // division stage output.
  logic               st_valid [MAX_PRECISION+1];
  logic               st_ready [MAX_PRECISION+1];
  ghe_pkg::div_item_t st_data  [MAX_PRECISION+1];

  // Config registers: take the write in the APB access phase.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lat_min <= ghe_pkg::LAT_MIN_RST;
      cfg.lat_max <= ghe_pkg::LAT_MAX_RST;
      cfg.lon_min <= ghe_pkg::LON_MIN_RST;
      cfg.lon_max <= ghe_pkg::LON_MAX_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ghe_pkg::REG_LAT_MIN: cfg.lat_min <= pwdata[30:0];
        ghe_pkg::REG_LAT_MAX: cfg.lat_max <= pwdata[30:0];
        ghe_pkg::REG_LON_MIN: cfg.lon_min <= pwdata;
        ghe_pkg::REG_LON_MAX: cfg.lon_max <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back sign-extended register values.
  always_comb begin
    case (paddr[3:2])
      ghe_pkg::REG_LAT_MIN: prdata = 32'(cfg.lat_min);
      ghe_pkg::REG_LAT_MAX: prdata = 32'(cfg.lat_max);
      ghe_pkg::REG_LON_MIN: prdata = cfg.lon_min;
      ghe_pkg::REG_LON_MAX: prdata = cfg.lon_max;
      default:              prdata = '0;
    endcase
  end

  ghe_front #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_data  (st_data[0])
  );

  // One stage per quotient bit, lat and lon lanes side by side.
  for (genvar k = 0; k < MAX_PRECISION; k++) begin : g_div
    ghe_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_data   (st_data[k]),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_data  (st_data[k+1])
    );
  end

  ghe_interleave #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_interleave (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[MAX_PRECISION]),
    .in_ready  (st_ready[MAX_PRECISION]),
    .in_data   (st_data[MAX_PRECISION]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/ghe_checker.sv @@
// Port-level checker for the geohash interleaved encoder, with its bind.
// Depends on ghe_pkg and geohash_interleaved_encoder_assert.svh.
`include "geohash_interleaved_encoder_assert.svh"

module ghe_checker #(
  parameter int MAX_PRECISION = 32
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input ghe_pkg::out_item_t out_data
);

  `GHE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `GHE_ASSERT_NOW(a_err_zero, clk, rst, out_valid && out_data.status != ghe_pkg::ST_OK, out_data.hash_bits == 64'd0)
  `GHE_ASSERT_NOW(a_status_code, clk, rst, out_valid, out_data.status <= ghe_pkg::ST_OUTSIDE)
  `GHE_ASSERT_NOW(a_ok_prec, clk, rst, out_valid && out_data.status == ghe_pkg::ST_OK, out_data.hash_precision != 8'd0 && out_data.hash_precision <= 8'(MAX_PRECISION))

endmodule

bind geohash_interleaved_encoder ghe_checker #(
  .MAX_PRECISION(MAX_PRECISION)
) u_ghe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
